// ===== rtl/lstl_pkg.sv =====
// ----------------------------------------------------------------------------
// lstl_pkg
// Types and constants for the line start table locator.
// ----------------------------------------------------------------------------
package lstl_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int LINE_W      = 11;
   localparam int STAT_W      = 2;

   typedef enum logic {
      OP_RECORD  = 1'b0,
      OP_RESOLVE = 1'b1
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADDR,
      ST_CMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              opcode;
      logic [WORD_W-1:0] offset;
   } req_type;

   typedef struct packed {
      logic [LINE_W-1:0] line_number;
      logic [WORD_W-1:0] column_number;
      logic [STAT_W-1:0] status;
   } rsp_type;

endpackage

// ===== rtl/line_start_table_locator.sv =====
// ----------------------------------------------------------------------------
// line_start_table_locator
// Line start table with append on record and binary search on resolve.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_data (opcode, offset)
//  rsp     | out       | rsp_valid, rsp_stall, rsp_data (line, column, status)
//
//  Record: accept, then the result transfer.
//  Resolve: S search steps (at most log2(depth)+1, 11 at 1024), then result;
//  each step is one read of the table RAM and one compare.
//  One item at a time: req_stall is high until the result transfer is taken.
//  Reset: synchronous; table holds the single start 0, no clearing pass.
// ----------------------------------------------------------------------------
module line_start_table_locator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lstl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lstl_pkg::rsp_type rsp_data
);

   localparam int IDX_W  = lstl_pkg::IDX_W;
   localparam int CNT_W  = lstl_pkg::CNT_W;
   localparam int WORD_W = lstl_pkg::WORD_W;

   lstl_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [WORD_W-1:0]   best_start_ff, best_start_in;
   logic [WORD_W-1:0]   offset_ff, offset_in;
   lstl_pkg::rsp_type   rsp_ff, rsp_in;

   logic [WORD_W-1:0]   starts_ff [lstl_pkg::TABLE_DEPTH];
   logic [WORD_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [WORD_W-1:0]   wr_data;

   logic [CNT_W-1:0]    mid_wide;
   logic [WORD_W-1:0]   cur_start;
   logic [CNT_W-1:0]    line_full;

   assign req_stall = (state_ff != lstl_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == lstl_pkg::ST_RESP);
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         starts_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= starts_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lstl_pkg::ST_IDLE;
         count_ff <= CNT_W'(1);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      best_ff       <= best_in;
      best_start_ff <= best_start_in;
      offset_ff     <= offset_in;
      rsp_ff        <= rsp_in;
   end

   // entry zero is never written; it always reads as zero
   assign mid_wide  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign cur_start = (mid_ff == '0) ? '0 : rd_data_ff;
   assign line_full = CNT_W'(best_ff) + CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      best_in       = best_ff;
      best_start_in = best_start_ff;
      offset_in     = offset_ff;
      rsp_in        = rsp_ff;
      rd_addr       = mid_wide[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = req_data.offset + WORD_W'(1);

      case (state_ff)
         lstl_pkg::ST_IDLE: begin
            if (req_valid) begin
               offset_in = req_data.offset;
               if (req_data.opcode == lstl_pkg::OP_RECORD) begin
                  rsp_in.line_number   = '0;
                  rsp_in.column_number = '0;
                  if (req_data.offset == '1) begin
                     rsp_in.status = lstl_pkg::STAT_OVERFLOW;
                  end else if (count_ff == CNT_W'(lstl_pkg::TABLE_DEPTH)) begin
                     rsp_in.status = lstl_pkg::STAT_FULL;
                  end else begin
                     rsp_in.status = lstl_pkg::STAT_OK;
                     wr_en         = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
                  state_in = lstl_pkg::ST_RESP;
               end else begin
                  lo_in         = '0;
                  hi_in         = count_ff - CNT_W'(1);
                  best_in       = '0;
                  best_start_in = '0;
                  state_in      = lstl_pkg::ST_ADDR;
               end
            end
         end
         lstl_pkg::ST_ADDR: begin
            if (lo_ff <= hi_ff) begin
               mid_in   = mid_wide[IDX_W-1:0];
               state_in = lstl_pkg::ST_CMP;
            end else begin
               rsp_in.line_number   = lstl_pkg::LINE_W'(line_full);
               rsp_in.column_number = offset_ff - best_start_ff + WORD_W'(1);
               rsp_in.status        = lstl_pkg::STAT_OK;
               state_in             = lstl_pkg::ST_RESP;
            end
         end
         lstl_pkg::ST_CMP: begin
            state_in = lstl_pkg::ST_ADDR;
            if (cur_start <= offset_ff) begin
               best_in       = mid_ff;
               best_start_in = cur_start;
               lo_in         = CNT_W'(mid_ff) + CNT_W'(1);
            end else if (mid_ff == '0) begin
               // search ends: force the exit test to fail
               lo_in = CNT_W'(1);
               hi_in = '0;
            end else begin
               hi_in = CNT_W'(mid_ff) - CNT_W'(1);
            end
         end
         lstl_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = lstl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lstl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
